// File: hw/rtl/huffman_tree_walk_decoder_macros.svh
// Assertion macros shared by the decoder modules.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing when SYNTHESIS is defined.
`ifndef HUFFMAN_TREE_WALK_DECODER_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons must hold too.
`define HTWD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("decoder assertion failed: same-cycle implication");

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define HTWD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("decoder assertion failed: next-cycle implication");

`else

`define HTWD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define HTWD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/htwd_pkg.sv
`default_nettype none

package htwd_pkg;

   localparam int NODE_SLOTS    = 512;
   localparam int SYMBOL_COUNT  = 256;
   localparam int BITS_PER_BYTE = 8;

   localparam int IDX_W     = $clog2(NODE_SLOTS);
   localparam int SYM_W     = $clog2(SYMBOL_COUNT);
   localparam int CNT_W     = $clog2(BITS_PER_BYTE + 1);
   localparam int BIT_POS_W = $clog2(BITS_PER_BYTE);

   localparam logic [CNT_W-1:0] BYTE_BITS = CNT_W'(BITS_PER_BYTE);

   // One stored tree node.
   typedef struct packed {
      logic             leaf;
      logic [SYM_W-1:0] symbol;
      logic [IDX_W-1:0] child_zero;
      logic [IDX_W-1:0] child_one;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   // Datapath operations issued by the controller.
   typedef logic [3:0] dp_op_type;

   localparam dp_op_type DP_NONE    = 4'd0;  // hold everything
   localparam dp_op_type DP_RD_ROOT = 4'd1;  // read the root node
   localparam dp_op_type DP_RD_CUR  = 4'd2;  // keep root word, read current node
   localparam dp_op_type DP_LD_W    = 4'd3;  // keep current node word
   localparam dp_op_type DP_EMIT_W  = 4'd4;  // current node is a leaf: emit it
   localparam dp_op_type DP_ISSUE_W = 4'd5;  // read the child of the current node
   localparam dp_op_type DP_EMIT_N  = 4'd6;  // fetched child is a leaf: emit it
   localparam dp_op_type DP_ADV_N   = 4'd7;  // step into child, read its child
   localparam dp_op_type DP_STOP_N  = 4'd8;  // step into child, no bits left
   localparam dp_op_type DP_FLUSH   = 4'd9;  // release held symbol, end the byte

   typedef struct packed {
      logic      load;     // write one node from the request fields
      logic      capture;  // latch the decode fields of the request
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic w_leaf;      // current node word is a leaf
      logic n_leaf;      // fetched child word is a leaf
      logic bits_done;   // no code bits left in the byte
      logic hold_valid;  // a symbol waits in the holding register
      logic slot_free;   // output register can take a symbol this cycle
   } dp_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/htwd_ram.sv
`default_nettype none

module htwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/htwd_ctrl.sv
`default_nettype none

`include "huffman_tree_walk_decoder_macros.svh"

module htwd_ctrl
   import htwd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_operation,
   output logic               req_stall,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROOTW = 2'd1;
   localparam logic [1:0] ST_LOADW = 2'd2;
   localparam logic [1:0] ST_WALK  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       pending_ff, pending_in;
   logic       emit_ok;
   logic       req_accept;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign emit_ok    = !status.hold_valid || status.slot_free;

   always_comb begin
      state_in    = state_ff;
      pending_in  = pending_ff;
      cmd.load    = 1'b0;
      cmd.capture = 1'b0;
      cmd.op      = DP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_operation) begin
                  cmd.capture = 1'b1;
                  cmd.op      = DP_RD_ROOT;
                  state_in    = ST_ROOTW;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_ROOTW: begin
            cmd.op   = DP_RD_CUR;
            state_in = ST_LOADW;
         end
         ST_LOADW: begin
            cmd.op     = DP_LD_W;
            pending_in = 1'b0;
            state_in   = ST_WALK;
         end
         ST_WALK: begin
            if (pending_ff) begin
               // A child read has returned and its word sits on the RAM read port.
               if (status.n_leaf) begin
                  if (emit_ok) begin
                     cmd.op     = DP_EMIT_N;
                     pending_in = 1'b0;
                  end
               end else if (!status.bits_done) begin
                  cmd.op = DP_ADV_N;
               end else begin
                  cmd.op     = DP_STOP_N;
                  pending_in = 1'b0;
               end
            end else if (status.bits_done) begin
               if (!status.hold_valid || status.slot_free) begin
                  cmd.op   = DP_FLUSH;
                  state_in = ST_IDLE;
               end
            end else if (status.w_leaf) begin
               if (emit_ok) begin
                  cmd.op = DP_EMIT_W;
               end
            end else begin
               cmd.op     = DP_ISSUE_W;
               pending_in = 1'b1;
            end
         end
         default: begin
            state_in   = ST_IDLE;
            pending_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
      end
   end

   `HTWD_ASSERT_IMPLY(a_pending_in_walk, clock, reset, pending_ff, state_ff == ST_WALK)
   `HTWD_ASSERT_NEXT(a_decode_starts, clock, reset, req_accept && req_operation, state_ff == ST_ROOTW)
   `HTWD_ASSERT_NEXT(a_flush_ends, clock, reset, cmd.op == DP_FLUSH, state_ff == ST_IDLE && !pending_ff)

endmodule

`default_nettype wire

// File: hw/rtl/htwd_datapath.sv
`default_nettype none

`include "huffman_tree_walk_decoder_macros.svh"

module htwd_datapath
   import htwd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dp_cmd_type       cmd,
   output dp_status_type         status,
   input  wire logic [IDX_W-1:0] req_node_index,
   input  wire logic             req_is_leaf,
   input  wire logic [SYM_W-1:0] req_leaf_symbol,
   input  wire logic [IDX_W-1:0] req_child_zero,
   input  wire logic [IDX_W-1:0] req_child_one,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic [CNT_W-1:0] req_bit_count,
   input  wire logic             req_last_byte,
   input  wire logic             csr_write_enable,
   input  wire logic [IDX_W-1:0] csr_write_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic      [SYM_W-1:0] rsp_symbol,
   output logic                  rsp_end_of_run
);

   logic [IDX_W-1:0] root_ff, root_in;
   logic [IDX_W-1:0] current_ff, current_in;
   logic [IDX_W-1:0] nidx_ff, nidx_in;
   node_type         w_ff, w_in;
   node_type         root_w_ff, root_w_in;
   logic [7:0]       data_ff, data_in;
   logic [CNT_W-1:0] bits_left_ff, bits_left_in;
   logic             last_ff, last_in;
   logic [SYM_W-1:0] hold_sym_ff, hold_sym_in;
   logic             hold_valid_ff, hold_valid_in;
   logic [SYM_W-1:0] rsp_symbol_ff, rsp_symbol_in;
   logic             rsp_end_ff, rsp_end_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   node_type         rd_node;
   node_type         wr_node;
   logic [CNT_W-1:0] bit_pos;
   logic             code_bit;
   logic [IDX_W-1:0] w_child;
   logic [IDX_W-1:0] n_child;
   logic             emit;
   logic [SYM_W-1:0] emit_sym;
   logic             slot_free;

   assign wr_node = '{leaf: req_is_leaf, symbol: req_leaf_symbol,
                      child_zero: req_child_zero, child_one: req_child_one};

   htwd_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_SLOTS)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (req_node_index),
      .wr_data (wr_node),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_node)
   );

   assign bit_pos   = bits_left_ff - CNT_W'(1);
   assign code_bit  = data_ff[bit_pos[BIT_POS_W-1:0]];
   assign w_child   = code_bit ? w_ff.child_one : w_ff.child_zero;
   assign n_child   = code_bit ? rd_node.child_one : rd_node.child_zero;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      root_in       = root_ff;
      current_in    = current_ff;
      nidx_in       = nidx_ff;
      w_in          = w_ff;
      root_w_in     = root_w_ff;
      data_in       = data_ff;
      bits_left_in  = bits_left_ff;
      last_in       = last_ff;
      hold_sym_in   = hold_sym_ff;
      hold_valid_in = hold_valid_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_valid_in  = rsp_valid_ff;
      rd_en         = 1'b0;
      rd_addr       = root_ff;
      emit          = 1'b0;
      emit_sym      = w_ff.symbol;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (cmd.op)
         DP_RD_ROOT: begin
            rd_en   = 1'b1;
            rd_addr = root_ff;
         end
         DP_RD_CUR: begin
            root_w_in = rd_node;
            rd_en     = 1'b1;
            rd_addr   = current_ff;
         end
         DP_LD_W: begin
            w_in = rd_node;
         end
         DP_EMIT_W: begin
            emit         = 1'b1;
            emit_sym     = w_ff.symbol;
            w_in         = root_w_ff;
            current_in   = root_ff;
            bits_left_in = bit_pos;
         end
         DP_ISSUE_W: begin
            rd_en        = 1'b1;
            rd_addr      = w_child;
            nidx_in      = w_child;
            bits_left_in = bit_pos;
         end
         DP_EMIT_N: begin
            emit       = 1'b1;
            emit_sym   = rd_node.symbol;
            w_in       = root_w_ff;
            current_in = root_ff;
         end
         DP_ADV_N: begin
            current_in   = nidx_ff;
            rd_en        = 1'b1;
            rd_addr      = n_child;
            nidx_in      = n_child;
            bits_left_in = bit_pos;
         end
         DP_STOP_N: begin
            current_in = nidx_ff;
            w_in       = rd_node;
         end
         DP_FLUSH: begin
            if (hold_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = hold_sym_ff;
               rsp_end_in    = last_ff;
               hold_valid_in = 1'b0;
            end
            if (last_ff) begin
               current_in = root_ff;
               w_in       = root_w_ff;
            end
         end
         default: begin
         end
      endcase

      // A new symbol pushes the held one out; the newest stays back so the
      // end-of-run flag can still be attached to it.
      if (emit) begin
         if (hold_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_symbol_in = hold_sym_ff;
            rsp_end_in    = 1'b0;
         end
         hold_sym_in   = emit_sym;
         hold_valid_in = 1'b1;
      end

      if (cmd.capture) begin
         data_in      = req_data_byte;
         bits_left_in = (req_bit_count > BYTE_BITS) ? BYTE_BITS : req_bit_count;
         last_in      = req_last_byte;
      end

      if (csr_write_enable) begin
         root_in    = csr_write_data;
         current_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff       <= '0;
         current_ff    <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         root_ff       <= root_in;
         current_ff    <= current_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nidx_ff       <= nidx_in;
      w_ff          <= w_in;
      root_w_ff     <= root_w_in;
      data_ff       <= data_in;
      bits_left_ff  <= bits_left_in;
      last_ff       <= last_in;
      hold_sym_ff   <= hold_sym_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign status.w_leaf     = w_ff.leaf;
   assign status.n_leaf     = rd_node.leaf;
   assign status.bits_done  = (bits_left_ff == '0);
   assign status.hold_valid = hold_valid_ff;
   assign status.slot_free  = slot_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_symbol     = rsp_symbol_ff;
   assign rsp_end_of_run = rsp_end_ff;

   `HTWD_ASSERT_IMPLY(a_no_overwrite, clock, reset, emit && hold_valid_ff, slot_free)
   `HTWD_ASSERT_IMPLY(a_bit_available, clock, reset, cmd.op == DP_EMIT_W || cmd.op == DP_ISSUE_W || cmd.op == DP_ADV_N, bits_left_ff != '0)

endmodule

`default_nettype wire

// File: hw/rtl/huffman_tree_walk_decoder.sv
// Load transfer: the node is written at the accepting edge.
// Decode transfer: setup reads the root node and the current node through the node RAM port and
// loads the current node word; the walk then takes the code bits, the symbols found at fetched
// children, a step when a byte ends inside a code, and a closing step, one byte at a time.
// Output stalls hold the walk; a symbol leaves on rsp_ once the next is found or at the close.
// Reset (synchronous, active high) sets root_index and the walk to node 0; node RAM is kept.
`default_nettype none

module huffman_tree_walk_decoder
   import htwd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,

   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_operation,
   input  wire logic [IDX_W-1:0] req_node_index,
   input  wire logic             req_is_leaf,
   input  wire logic [SYM_W-1:0] req_leaf_symbol,
   input  wire logic [IDX_W-1:0] req_child_zero,
   input  wire logic [IDX_W-1:0] req_child_one,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic [CNT_W-1:0] req_bit_count,
   input  wire logic             req_last_byte,

   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic      [SYM_W-1:0] rsp_symbol,
   output logic                  rsp_end_of_run,

   input  wire logic             csr_write_enable,
   input  wire logic [IDX_W-1:0] csr_write_data
);

   // The controller sequences one request at a time. A load transfer writes a
   // node straight into the node RAM and the block is ready again in the next
   // cycle. A decode transfer first reads the root node and the node the walk
   // currently stands on, because loads may have changed either since the last
   // byte. Unless the output stalls, the walk then runs one code bit per cycle: the
   // word of the current node is held in a register or comes straight out of the RAM
   // read port, and the child chosen by the bit is addressed in the same cycle. When a
   // fetched child is a leaf, its symbol is taken in a step of its own and the walk
   // restarts from the held root word.
   //
   // Found symbols pass through a one-entry holding register before the
   // output register, so the last symbol of a final byte can carry its
   // end-of-run flag. The output register frees the controller from the
   // consumer: the next request is taken while a result still waits for its
   // transfer. A code left unfinished at a final byte is dropped and the walk
   // goes back to the root.
   //
   // Writing the root register also moves the walk to the new root.

   dp_cmd_type    cmd;
   dp_status_type status;

   htwd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   htwd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_node_index   (req_node_index),
      .req_is_leaf      (req_is_leaf),
      .req_leaf_symbol  (req_leaf_symbol),
      .req_child_zero   (req_child_zero),
      .req_child_one    (req_child_one),
      .req_data_byte    (req_data_byte),
      .req_bit_count    (req_bit_count),
      .req_last_byte    (req_last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_symbol       (rsp_symbol),
      .rsp_end_of_run   (rsp_end_of_run)
   );

endmodule

`default_nettype wire
